FILE: rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared geometry, types and helpers of the set-associative write-back cache.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int NUM_SETS    = 32;
  localparam int NUM_WAYS    = 2;
  localparam int BLOCK_BYTES = 16;
  localparam int ADDR_BITS   = 32;

  localparam int FIELD_W     = 32;
  localparam int CNT_W       = 32;

  localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int TAG_BITS    = ADDR_BITS - SET_BITS - OFFSET_BITS;
  localparam int WAY_BITS    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RANK_BITS   = WAY_BITS;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // one memory row holds a whole set
  typedef struct packed {
    logic [NUM_WAYS-1:0]                valid;
    logic [NUM_WAYS-1:0]                dirty;
    logic [NUM_WAYS-1:0][RANK_BITS-1:0] rank;
    logic [NUM_WAYS-1:0][TAG_BITS-1:0]  tag;
  } set_row_t;

  localparam int ROW_W = $bits(set_row_t);

  typedef struct packed {
    logic               hit;
    logic               write_back;
    logic [FIELD_W-1:0] victim_address;
    logic               way_used;
    set_row_t           new_row;
  } lookup_t;

  typedef struct packed {
    logic [CNT_W-1:0] reads;
    logic [CNT_W-1:0] read_misses;
    logic [CNT_W-1:0] writes;
    logic [CNT_W-1:0] write_misses;
  } totals_t;

  function automatic set_row_t reset_row();
    set_row_t r;
    r.valid = '0;
    r.dirty = '0;
    r.tag   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rank[w] = RANK_BITS'(NUM_WAYS - 1);
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

FILE: rtl/salc_chan_if.sv
// ----------------------------------------------------------------------------
// salc_req_if / salc_rsp_if
// Valid/ready channels for cache accesses and their results.
// ----------------------------------------------------------------------------
interface salc_req_if import salc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [FIELD_W-1:0]   address;

  modport source (output valid, func, address, input ready);
  modport sink   (input valid, func, address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 fetch_from_next;
  logic                 write_back;
  logic [FIELD_W-1:0]   victim_address;
  logic                 way_used;
  logic [CNT_W-1:0]     read_total;
  logic [CNT_W-1:0]     read_miss_total;
  logic [CNT_W-1:0]     write_total;
  logic [CNT_W-1:0]     write_miss_total;

  modport source (output valid, hit, fetch_from_next, write_back, victim_address, way_used,
                  read_total, read_miss_total, write_total, write_miss_total,
                  input ready);
  modport sink   (input valid, hit, fetch_from_next, write_back, victim_address, way_used,
                  read_total, read_miss_total, write_total, write_miss_total,
                  output ready);
endinterface

FILE: rtl/salc_lookup.sv
// ----------------------------------------------------------------------------
// salc_lookup
// Tag compare over all ways of a set, victim choice and the updated set row.
// ----------------------------------------------------------------------------
module salc_lookup import salc_pkg::*; (
  input  logic                func,
  input  logic [TAG_BITS-1:0] tag,
  input  logic [SET_BITS-1:0] set_idx,
  input  set_row_t            row,
  output lookup_t             res
);

  always_comb begin
    logic                 found_hit;
    logic                 found_inv;
    logic [WAY_BITS-1:0]  hit_way;
    logic [WAY_BITS-1:0]  inv_way;
    logic [WAY_BITS-1:0]  lru_way;
    logic [WAY_BITS-1:0]  way;
    logic [RANK_BITS-1:0] best;
    logic [RANK_BITS-1:0] old;
    logic                 wb;
    set_row_t             nr;

    found_hit = 1'b0;
    found_inv = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found_hit && row.valid[w] && row.tag[w] == tag) begin
        found_hit = 1'b1;
        hit_way   = WAY_BITS'(w);
      end
      if (!found_inv && !row.valid[w]) begin
        found_inv = 1'b1;
        inv_way   = WAY_BITS'(w);
      end
    end

    // highest rank wins, lowest way on a tie
    best    = row.rank[0];
    lru_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (row.rank[w] > best) begin
        best    = row.rank[w];
        lru_way = WAY_BITS'(w);
      end
    end

    if (found_hit) begin
      way = hit_way;
    end else if (found_inv) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end

    wb = !found_hit && !found_inv && row.dirty[lru_way];

    nr = row;
    if (found_hit) begin
      if (func == FUNC_WRITE) begin
        nr.dirty[way] = 1'b1;
      end
    end else begin
      nr.tag[way]   = tag;
      nr.valid[way] = 1'b1;
      nr.dirty[way] = (func == FUNC_WRITE);
    end

    old = row.rank[way];
    for (int k = 0; k < NUM_WAYS; k++) begin
      if (row.rank[k] < old) begin
        nr.rank[k] = row.rank[k] + 1'b1;
      end
    end
    nr.rank[way] = '0;

    res.hit            = found_hit;
    res.write_back     = wb;
    res.victim_address = wb ? FIELD_W'({row.tag[lru_way], set_idx, {OFFSET_BITS{1'b0}}})
                            : '0;
    res.way_used       = way[0];
    res.new_row        = nr;
  end

endmodule

FILE: rtl/salc_counters.sv
// ----------------------------------------------------------------------------
// salc_counters
// Saturating access and miss counters, split by reads and writes.
// ----------------------------------------------------------------------------
module salc_counters import salc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  logic    func,
  input  logic    hit,
  output totals_t totals_next
);

  totals_t totals;

  always_comb begin
    totals_next = totals;
    if (func == FUNC_WRITE) begin
      totals_next.writes = sat_inc(totals.writes);
      if (!hit) begin
        totals_next.write_misses = sat_inc(totals.write_misses);
      end
    end else begin
      totals_next.reads = sat_inc(totals.reads);
      if (!hit) begin
        totals_next.read_misses = sat_inc(totals.read_misses);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals <= '0;
    end else if (fire) begin
      totals <= totals_next;
    end
  end

endmodule

FILE: rtl/set_assoc_lru_writeback_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache
// Tag-only set-associative write-back cache with true-LRU replacement.
// ----------------------------------------------------------------------------
// Accesses come in on req (func: 0 read, 1 write; byte address) and one
// result per access leaves on rsp: hit, fetch_from_next on a miss, write_back
// with the block address of a dirty victim, the way used and four saturating
// totals counted up to and including this access.
// The set row (tags, valid, dirty, LRU ranks of all ways) sits in a
// synchronous memory of NUM_SETS rows. An access reads its row at the accept
// edge, the compare and update run in the next cycle, and the row is written
// back and the result registered when that compare stage fires. One access
// per cycle is sustained while rsp is not stalled; a following
// access to the same set takes the just-written row through a bypass register.
// Reset clears a per-set initialised flag and the totals, so the block takes
// accesses from the first cycle after reset with no clearing pass; a set
// never written reads as all ways invalid with full rank.
// When rsp is stalled the result register holds, the access in the compare
// stage waits, and req.ready drops once that stage is full.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache import salc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  salc_req_if.sink     req,
  salc_rsp_if.source   rsp
);

  logic [ROW_W-1:0]    mem [NUM_SETS];
  logic [ROW_W-1:0]    mem_q;
  logic [NUM_SETS-1:0] row_init;

  logic                s1_valid;
  logic                s1_func;
  logic [SET_BITS-1:0] s1_set;
  logic [TAG_BITS-1:0] s1_tag;
  logic                s1_init;
  logic                s1_byp;
  set_row_t            s1_byp_row;

  logic                s1_fire;
  logic                in_fire;
  logic [SET_BITS-1:0] in_set;
  set_row_t            s1_row;
  lookup_t             lk;
  totals_t             totals_next;

  assign in_set  = req.address[OFFSET_BITS +: SET_BITS];
  assign s1_fire = s1_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !s1_valid || s1_fire;
  assign in_fire = req.valid && req.ready;

  // row seen by the compare stage
  always_comb begin
    if (s1_byp) begin
      s1_row = s1_byp_row;
    end else if (s1_init) begin
      s1_row = set_row_t'(mem_q);
    end else begin
      s1_row = reset_row();
    end
  end

  salc_lookup u_lookup (
    .func    (s1_func),
    .tag     (s1_tag),
    .set_idx (s1_set),
    .row     (s1_row),
    .res     (lk)
  );

  salc_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .fire        (s1_fire),
    .func        (s1_func),
    .hit         (lk.hit),
    .totals_next (totals_next)
  );

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      mem[s1_set] <= ROW_W'(lk.new_row);
    end
    if (in_fire) begin
      mem_q <= mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_init  <= '0;
      s1_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (s1_fire) begin
        row_init[s1_set] <= 1'b1;
        rsp.valid        <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func    <= req.func;
      s1_set     <= in_set;
      s1_tag     <= req.address[ADDR_BITS-1 -: TAG_BITS];
      s1_init    <= row_init[in_set];
      s1_byp     <= s1_fire && (s1_set == in_set);
      s1_byp_row <= lk.new_row;
    end
    if (s1_fire) begin
      rsp.hit              <= lk.hit;
      rsp.fetch_from_next  <= !lk.hit;
      rsp.write_back       <= lk.write_back;
      rsp.victim_address   <= lk.victim_address;
      rsp.way_used         <= lk.way_used;
      rsp.read_total       <= totals_next.reads;
      rsp.read_miss_total  <= totals_next.read_misses;
      rsp.write_total      <= totals_next.writes;
      rsp.write_miss_total <= totals_next.write_misses;
    end
  end

  a_hit_xor_fetch: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.hit != rsp.fetch_from_next))
    else $error("hit and fetch_from_next disagree");

  a_wb_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.write_back |-> !rsp.hit)
    else $error("write-back raised on a hit");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> rsp.valid)
    else $error("compare stage fired without a result");

  a_valid_ways_grow: assert property (@(posedge clk) disable iff (rst)
    s1_fire |-> $countones(lk.new_row.valid) >= $countones(s1_row.valid))
    else $error("an access dropped a valid way");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid && $stable(s1_set))
    else $error("stalled access lost from the compare stage");

endmodule
